### src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes of the best-fit block allocator: result codes,
// action codes, controller states, datapath operations and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Fixed field widths of the transfer payloads
  localparam int ACTION_W = 1;
  localparam int REQ_W    = 11;
  localparam int ADDR_W   = 10;
  localparam int STATUS_W = 2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STS_UNKNOWN = 2'd3;

  // Controller states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_WR_SPLIT,
    S_WR_BEST,
    S_COMPACT,
    S_COMPACT_END,
    S_RESP
  } ctrl_state_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_START,
    OP_SCAN,
    OP_PREP,
    OP_SHIFT,
    OP_WR_SPLIT,
    OP_WR_BEST,
    OP_COMPACT,
    OP_COMPACT_END
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t              op;
    logic                load_out;
    logic [STATUS_W-1:0] res_code;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic null_free;
    logic is_free;
    logic scan_done;
    logic found;
    logic split;
    logic hit;
    logic hit_free;
    logic shift_done;
    logic compact_done;
  } dp_stat_t;

endpackage

### src/bfa_cmd_if.sv
// ----------------------------------------------------------------------------
// bfa_cmd_if
// Request channel of the allocator: allocate or free, with valid/ready.
// ----------------------------------------------------------------------------
interface bfa_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::ACTION_W-1:0] action;
  logic [bfa_pkg::REQ_W-1:0]    req_size;
  logic [bfa_pkg::ADDR_W-1:0]   payload_addr;

  modport source (output valid, action, req_size, payload_addr, input ready);
  modport sink   (input valid, action, req_size, payload_addr, output ready);
endinterface

### src/bfa_res_if.sv
// ----------------------------------------------------------------------------
// bfa_res_if
// Result channel of the allocator: status and granted offset, valid/ready.
// ----------------------------------------------------------------------------
interface bfa_res_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::STATUS_W-1:0] status;
  logic [bfa_pkg::ADDR_W-1:0]   granted_addr;

  modport source (output valid, status, granted_addr, input ready);
  modport sink   (input valid, status, granted_addr, output ready);
endinterface

### src/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Controller of the allocator. Sequences scan, table shift, coalescing pass
// and result hand-off; owns the channel handshakes.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  bfa_pkg::dp_stat_t stat,
  output bfa_pkg::dp_cmd_t  ctl
);

  bfa_pkg::ctrl_state_t          state, state_next;
  logic [bfa_pkg::STATUS_W-1:0]  res_code, res_code_next;

  // State and pending result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bfa_pkg::S_INIT;
      res_code <= bfa_pkg::STS_DONE;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    cmd_ready     = 1'b0;
    ctl.op        = bfa_pkg::OP_NONE;
    ctl.load_out  = 1'b0;
    ctl.res_code  = res_code;
    unique case (state)
      bfa_pkg::S_INIT: begin
        ctl.op     = bfa_pkg::OP_INIT;
        state_next = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.op = bfa_pkg::OP_START;
          if (stat.null_free) begin
            res_code_next = bfa_pkg::STS_NULL;
            state_next    = bfa_pkg::S_RESP;
          end else begin
            state_next = bfa_pkg::S_SCAN;
          end
        end
      end
      bfa_pkg::S_SCAN: begin
        ctl.op = bfa_pkg::OP_SCAN;
        if (stat.scan_done) begin
          state_next = bfa_pkg::S_DECIDE;
        end
      end
      bfa_pkg::S_DECIDE: begin
        ctl.op = bfa_pkg::OP_PREP;
        if (!stat.is_free) begin
          if (!stat.found) begin
            res_code_next = bfa_pkg::STS_NOFIT;
            state_next    = bfa_pkg::S_RESP;
          end else if (stat.split) begin
            state_next = bfa_pkg::S_SHIFT;
          end else begin
            state_next = bfa_pkg::S_WR_BEST;
          end
        end else if (!stat.hit || stat.hit_free) begin
          res_code_next = bfa_pkg::STS_UNKNOWN;
          state_next    = bfa_pkg::S_RESP;
        end else begin
          state_next = bfa_pkg::S_COMPACT;
        end
      end
      bfa_pkg::S_SHIFT: begin
        ctl.op = bfa_pkg::OP_SHIFT;
        if (stat.shift_done) begin
          state_next = bfa_pkg::S_WR_SPLIT;
        end
      end
      bfa_pkg::S_WR_SPLIT: begin
        ctl.op     = bfa_pkg::OP_WR_SPLIT;
        state_next = bfa_pkg::S_WR_BEST;
      end
      bfa_pkg::S_WR_BEST: begin
        ctl.op        = bfa_pkg::OP_WR_BEST;
        res_code_next = bfa_pkg::STS_DONE;
        state_next    = bfa_pkg::S_RESP;
      end
      bfa_pkg::S_COMPACT: begin
        ctl.op = bfa_pkg::OP_COMPACT;
        if (stat.compact_done) begin
          state_next = bfa_pkg::S_COMPACT_END;
        end
      end
      bfa_pkg::S_COMPACT_END: begin
        ctl.op        = bfa_pkg::OP_COMPACT_END;
        res_code_next = bfa_pkg::STS_DONE;
        state_next    = bfa_pkg::S_RESP;
      end
      bfa_pkg::S_RESP: begin
        // wait for a free output register
        if (!res_valid || res_ready) begin
          ctl.load_out = 1'b1;
          state_next   = bfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfa_pkg::S_INIT;
      end
    endcase
  end

endmodule

### src/bfa_dp.sv
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath of the allocator: block table memory (size and free mark per
// entry), scan registers, shift and coalescing stream, result registers.
// ----------------------------------------------------------------------------
module bfa_dp #(
  parameter int HEAP_BYTES   = 1024,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bfa_pkg::dp_cmd_t             ctl,
  output bfa_pkg::dp_stat_t            stat,
  input  logic [bfa_pkg::ACTION_W-1:0] cmd_action,
  input  logic [bfa_pkg::REQ_W-1:0]    cmd_req_size,
  input  logic [bfa_pkg::ADDR_W-1:0]   cmd_payload_addr,
  output logic [bfa_pkg::STATUS_W-1:0] res_status,
  output logic [bfa_pkg::ADDR_W-1:0]   res_granted_addr
);

  localparam int SZ_W  = $clog2(HEAP_BYTES);
  localparam int OFF_W = SZ_W + 1;
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = ((SZ_W > bfa_pkg::REQ_W) ? SZ_W : bfa_pkg::REQ_W) + 1;
  localparam int AW    = (OFF_W > bfa_pkg::ADDR_W) ? OFF_W : bfa_pkg::ADDR_W;

  localparam logic [OFF_W-1:0] HDR_OFF   = OFF_W'(HEADER_BYTES);
  localparam logic [CMP_W-1:0] HDR_CMP   = CMP_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0]  INIT_SIZE = SZ_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
  localparam logic [IDX_W-1:0] ONE_IDX   = IDX_W'(1);

  // Block table: {free, size}
  logic [SZ_W:0]                mem [MAX_BLOCKS];
  logic [SZ_W:0]                rd_data;
  logic [IDX_W-1:0]             ra;
  logic                         we;
  logic [IDX_W-1:0]             wa;
  logic [SZ_W:0]                wd;
  logic                         issue;

  // Request and scan registers
  logic [bfa_pkg::ACTION_W-1:0] act;
  logic [bfa_pkg::REQ_W-1:0]    req;
  logic [bfa_pkg::ADDR_W-1:0]   addr;
  logic [CNT_W-1:0]             count, count_next;
  logic [CNT_W-1:0]             r_idx, w_idx;
  logic [IDX_W-1:0]             p_idx;
  logic                         rd_vld;
  logic [OFF_W-1:0]             off;
  logic                         found;
  logic [IDX_W-1:0]             best_idx;
  logic [SZ_W-1:0]              best_size;
  logic [OFF_W-1:0]             best_off;
  logic                         hit, hit_free;
  logic [IDX_W-1:0]             hit_idx;
  logic                         have_pend, pend_free;
  logic [SZ_W-1:0]              pend_size;

  // Derived values
  logic [SZ_W-1:0]              rd_size;
  logic                         rd_free;
  logic                         is_free;
  logic                         split;
  logic [SZ_W-1:0]              split_size;
  logic [CNT_W-1:0]             r_dec;
  logic [CNT_W-1:0]             best_next;
  logic [CNT_W-1:0]             start_idx;
  logic                         fits, better, addr_match, e_free, merge;
  logic [OFF_W-1:0]             off_step;
  logic [SZ_W-1:0]              merged_size;

  assign rd_size     = rd_data[SZ_W-1:0];
  assign rd_free     = rd_data[SZ_W];
  assign is_free     = (act == bfa_pkg::ACT_FREE);
  assign r_dec       = r_idx - ONE_CNT;
  assign best_next   = CNT_W'(best_idx) + ONE_CNT;
  assign start_idx   = (hit_idx == '0) ? '0 : CNT_W'(hit_idx) - ONE_CNT;
  assign split       = (CMP_W'(best_size) > (CMP_W'(req) + HDR_CMP)) && (count != MAX_CNT);
  assign split_size  = SZ_W'(CMP_W'(best_size) - CMP_W'(req) - HDR_CMP);
  assign fits        = rd_free && (CMP_W'(rd_size) >= CMP_W'(req));
  assign better      = !found || (rd_size < best_size);
  assign addr_match  = (AW'(off) == AW'(addr));
  assign off_step    = off + HDR_OFF + OFF_W'(rd_size);
  assign e_free      = rd_free || (p_idx == hit_idx);
  assign merge       = pend_free && e_free;
  assign merged_size = SZ_W'(OFF_W'(pend_size) + OFF_W'(rd_size) + HDR_OFF);

  // Status to the controller
  always_comb begin
    stat.null_free    = (cmd_action == bfa_pkg::ACT_FREE) && (cmd_payload_addr == '0);
    stat.is_free      = is_free;
    stat.scan_done    = hit || ((r_idx == count) && !rd_vld);
    stat.found        = found;
    stat.split        = split;
    stat.hit          = hit;
    stat.hit_free     = hit_free;
    stat.shift_done   = !(r_idx > best_next) && !rd_vld;
    stat.compact_done = (r_idx == count) && !rd_vld;
  end

  // Read issue and table write selection
  always_comb begin
    issue = 1'b0;
    ra    = r_idx[IDX_W-1:0];
    we    = 1'b0;
    wa    = best_idx;
    wd    = rd_data;
    unique case (ctl.op)
      bfa_pkg::OP_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = {1'b1, INIT_SIZE};
      end
      bfa_pkg::OP_SCAN: begin
        issue = (r_idx != count);
      end
      bfa_pkg::OP_SHIFT: begin
        issue = (r_idx > best_next);
        ra    = r_dec[IDX_W-1:0];
        // move each entry one place up
        we    = rd_vld;
        wa    = p_idx + ONE_IDX;
        wd    = rd_data;
      end
      bfa_pkg::OP_WR_SPLIT: begin
        we = 1'b1;
        wa = best_idx + ONE_IDX;
        wd = {1'b1, split_size};
      end
      bfa_pkg::OP_WR_BEST: begin
        we = 1'b1;
        wa = best_idx;
        wd = {1'b0, split ? SZ_W'(req) : best_size};
      end
      bfa_pkg::OP_COMPACT: begin
        issue = (r_idx != count);
        // retire the pending block when the incoming one does not join it
        we    = rd_vld && have_pend && !merge;
        wa    = w_idx[IDX_W-1:0];
        wd    = {pend_free, pend_size};
      end
      bfa_pkg::OP_COMPACT_END: begin
        we = 1'b1;
        wa = w_idx[IDX_W-1:0];
        wd = {pend_free, pend_size};
      end
      bfa_pkg::OP_NONE, bfa_pkg::OP_START, bfa_pkg::OP_PREP: begin
        issue = 1'b0;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Table memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // Block count
  always_comb begin
    count_next = count;
    if (ctl.op == bfa_pkg::OP_WR_BEST && split) begin
      count_next = count + ONE_CNT;
    end else if (ctl.op == bfa_pkg::OP_COMPACT_END) begin
      count_next = w_idx + ONE_CNT;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= ONE_CNT;
      rd_vld <= 1'b0;
    end else begin
      count  <= count_next;
      rd_vld <= issue;
    end
  end

  // Scan, shift and coalescing registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      bfa_pkg::OP_START: begin
        act   <= cmd_action;
        req   <= cmd_req_size;
        addr  <= cmd_payload_addr;
        r_idx <= '0;
        off   <= HDR_OFF;
        found <= 1'b0;
        hit   <= 1'b0;
      end
      bfa_pkg::OP_SCAN: begin
        if (issue) begin
          r_idx <= r_idx + ONE_CNT;
        end
        p_idx <= r_idx[IDX_W-1:0];
        if (rd_vld && !hit) begin
          off <= off_step;
          if (!is_free) begin
            // smallest fitting free block, earliest on a tie
            if (fits && better) begin
              found     <= 1'b1;
              best_idx  <= p_idx;
              best_size <= rd_size;
              best_off  <= off;
            end
          end else if (addr_match) begin
            hit      <= 1'b1;
            hit_idx  <= p_idx;
            hit_free <= rd_free;
          end
        end
      end
      bfa_pkg::OP_PREP: begin
        have_pend <= 1'b0;
        if (!is_free) begin
          r_idx <= count;
        end else begin
          r_idx <= start_idx;
          w_idx <= start_idx;
        end
      end
      bfa_pkg::OP_SHIFT: begin
        if (issue) begin
          r_idx <= r_dec;
        end
        p_idx <= r_dec[IDX_W-1:0];
      end
      bfa_pkg::OP_COMPACT: begin
        if (issue) begin
          r_idx <= r_idx + ONE_CNT;
        end
        p_idx <= r_idx[IDX_W-1:0];
        if (rd_vld) begin
          have_pend <= 1'b1;
          if (have_pend && merge) begin
            pend_size <= merged_size;
          end else begin
            if (have_pend) begin
              w_idx <= w_idx + ONE_CNT;
            end
            pend_size <= rd_size;
            pend_free <= e_free;
          end
        end
      end
      bfa_pkg::OP_NONE, bfa_pkg::OP_INIT, bfa_pkg::OP_WR_SPLIT,
      bfa_pkg::OP_WR_BEST, bfa_pkg::OP_COMPACT_END: begin
      end
      default: begin
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      res_status <= ctl.res_code;
      if (ctl.res_code == bfa_pkg::STS_DONE && !is_free) begin
        res_granted_addr <= bfa_pkg::ADDR_W'(best_off);
      end else begin
        res_granted_addr <= '0;
      end
    end
  end

endmodule

### src/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit heap allocator with coalescing. The heap is kept as a table of
// blocks in address order; allocate picks the smallest fitting free block
// and may split it, free marks a block free and merges it with free neighbors.
//
//   channel | dir | transfer payload
//   --------+-----+--------------------------------------------
//   cmd     | in  | action, req_size, payload_addr
//   res     | out | status, granted_addr
//
// One request at a time. Allocate scans the table; it splits the block only
// when the rest can hold a header plus a byte and the table has room, and
// then shifts the entries above the split point through the single read port.
// Free scans to the address, then makes one coalescing pass from the block
// before it. Reset is synchronous; the first cycle after reset writes the
// initial block and no request is taken then. The next request is taken
// while a result still waits in the output register; a stalled result
// holds the block at the end of its work.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
  parameter int HEAP_BYTES   = 1024,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input logic      clk,
  input logic      rst,
  bfa_cmd_if.sink  cmd,
  bfa_res_if.source res
);

  bfa_pkg::dp_cmd_t  ctl;
  bfa_pkg::dp_stat_t stat;

  // Sequencer
  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Block table and arithmetic
  bfa_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .stat             (stat),
    .cmd_action       (cmd.action),
    .cmd_req_size     (cmd.req_size),
    .cmd_payload_addr (cmd.payload_addr),
    .res_status       (res.status),
    .res_granted_addr (res.granted_addr)
  );

endmodule

### src/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the allocator: result hold under stall, one request
// in flight, result codes against offsets, reset behavior, work before results.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [bfa_pkg::STATUS_W-1:0] status,
  input logic [bfa_pkg::ADDR_W-1:0]   granted_addr
);

  // A stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(granted_addr))
    else $error("result changed while stalled");

  // Only one request in flight: no transfer in the cycle after a transfer
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken while busy");

  // Only a completed result carries an offset
  a_addr_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (status == bfa_pkg::STS_DONE) || (granted_addr == '0))
    else $error("offset on a failed or free result");

  // Out of reset nothing is offered and nothing is taken
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !cmd_ready)
    else $error("channel active right after reset");

  // A new result appears only after the block was busy
  a_res_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(cmd_ready))
    else $error("result without preceding work");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .status       (res.status),
  .granted_addr (res.granted_addr)
);

### dv/best_fit_block_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_checker
// Watches the request and result channels of the allocator. It keeps its own
// copy of the block table, works out the status and granted offset of every
// accepted request, and compares each result transfer in order. It reports
// the mismatch count and the number of results still due.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_checker #(
  parameter int HEAP_BYTES   = 1024,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic clk,
  input  logic rst,
  bfa_cmd_if   cmd,
  bfa_res_if   res,
  output int   fail_count,
  output int   results_due
);

  typedef struct packed {
    logic [bfa_pkg::STATUS_W-1:0] status;
    logic [bfa_pkg::ADDR_W-1:0]   granted_addr;
  } outcome_t;

  // Block table in address order
  logic [bfa_pkg::REQ_W-1:0] blk_size [MAX_BLOCKS];
  logic                      blk_free [MAX_BLOCKS];
  int                        blk_count;

  outcome_t outcome_q[$];
  int       mismatches;

  // Apply one request to the table and return its outcome
  function automatic outcome_t predict_outcome(logic [bfa_pkg::ACTION_W-1:0] act,
                                               logic [bfa_pkg::REQ_W-1:0] req,
                                               logic [bfa_pkg::ADDR_W-1:0] addr);
    int       i;
    int       j;
    int       best;
    int       off;
    int       hit;
    bit       found;
    outcome_t outcome;
    outcome = '{status: bfa_pkg::STS_DONE, granted_addr: '0};
    if (act == bfa_pkg::ACT_ALLOC) begin
      // Smallest fitting free block, earliest on a tie
      found = 1'b0;
      best  = 0;
      for (i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_size[i] >= req) begin
          if (!found || blk_size[i] < blk_size[best]) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        outcome.status = bfa_pkg::STS_NOFIT;
        return outcome;
      end
      // Split only when the remainder can hold a header plus a byte
      if (int'(blk_size[best]) > int'(req) + HEADER_BYTES && blk_count < MAX_BLOCKS) begin
        for (j = blk_count; j > best + 1; j--) begin
          blk_size[j] = blk_size[j-1];
          blk_free[j] = blk_free[j-1];
        end
        blk_size[best+1] = bfa_pkg::REQ_W'(int'(blk_size[best]) - int'(req) - HEADER_BYTES);
        blk_free[best+1] = 1'b1;
        blk_size[best]   = req;
        blk_count++;
      end
      blk_free[best] = 1'b0;
      off = HEADER_BYTES;
      for (i = 0; i < best; i++) off += HEADER_BYTES + int'(blk_size[i]);
      outcome.granted_addr = bfa_pkg::ADDR_W'(off);
    end else begin
      if (addr == '0) begin
        outcome.status = bfa_pkg::STS_NULL;
        return outcome;
      end
      // Locate the block whose payload starts at addr
      off = HEADER_BYTES;
      hit = -1;
      for (i = 0; i < blk_count && hit < 0; i++) begin
        if (off == int'(addr)) hit = i;
        off += HEADER_BYTES + int'(blk_size[i]);
      end
      if (hit < 0 || blk_free[hit]) begin
        outcome.status = bfa_pkg::STS_UNKNOWN;
        return outcome;
      end
      blk_free[hit] = 1'b1;
      // Merge every run of adjacent free blocks
      i = 0;
      while (i + 1 < blk_count) begin
        if (blk_free[i] && blk_free[i+1]) begin
          blk_size[i] = bfa_pkg::REQ_W'(int'(blk_size[i]) + int'(blk_size[i+1]) + HEADER_BYTES);
          for (j = i + 1; j + 1 < blk_count; j++) begin
            blk_size[j] = blk_size[j+1];
            blk_free[j] = blk_free[j+1];
          end
          blk_count--;
          blk_size[blk_count] = '0;
          blk_free[blk_count] = 1'b0;
        end else begin
          i++;
        end
      end
    end
    return outcome;
  endfunction

  // Result check first: a result at this edge belongs to an earlier request
  always @(posedge clk) begin
    outcome_t expv;
    if (rst) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        blk_size[k] = '0;
        blk_free[k] = 1'b0;
      end
      blk_size[0] = bfa_pkg::REQ_W'(HEAP_BYTES - HEADER_BYTES);
      blk_free[0] = 1'b1;
      blk_count   = 1;
      outcome_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result transfer, expected none, actual status %0d addr %0d",
                   $time, res.status, res.granted_addr);
          mismatches++;
        end else begin
          expv = outcome_q.pop_front();
          if (res.status !== expv.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, expv.status, res.status);
            mismatches++;
          end
          if (res.granted_addr !== expv.granted_addr) begin
            $display("%0t: granted_addr mismatch, expected %0d, actual %0d",
                     $time, expv.granted_addr, res.granted_addr);
            mismatches++;
          end
        end
      end
      if (cmd.valid && cmd.ready)
        outcome_q.push_back(predict_outcome(cmd.action, cmd.req_size, cmd.payload_addr));
    end
    fail_count  <= mismatches;
    results_due <= outcome_q.size();
  end

endmodule

### dv/best_fit_block_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_tb
// Drives allocate and free requests into the allocator: a directed opening
// over exact fits, splits, ties, null and bad frees, then random episodes of
// table fill-ups and mixed traffic with random idling on both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORK_ITEMS  = 1200;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   results_due;
  int   results_taken;
  int   sent_count;
  int   cycles;
  int   live_addrs[$];
  int   last_freed;

  bfa_cmd_if cmd_ch ();
  bfa_res_if res_ch ();

  best_fit_block_allocator uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  best_fit_block_allocator_checker alloc_chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("best_fit_block_allocator verification failed");
      $finish;
    end
  end

  // Track granted offsets so frees can target live blocks
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_taken++;
      if (res_ch.status == bfa_pkg::STS_DONE && res_ch.granted_addr != '0)
        live_addrs.push_back(int'(res_ch.granted_addr));
    end
  end

  // Result side: random stalls, one long hold-off, one window with no stalls
  initial begin
    int  hold_left;
    bit  hold_done;
    res_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_ch.ready = 1'b0;
      end else if (!hold_done && results_taken >= 250) begin
        hold_done    = 1'b1;
        hold_left    = 400;
        res_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready = 1'b0;
      end else if (results_taken >= 600 && results_taken < 800) begin
        res_ch.ready = 1'b1;
      end else begin
        res_ch.ready = ($urandom_range(99) >= 38);
      end
    end
  end

  // One request transfer, entered and left at a falling edge
  task automatic send_cmd(input logic [bfa_pkg::ACTION_W-1:0] act, input int size,
                          input int addr);
    if (!(sent_count >= 500 && sent_count < 700) && $urandom_range(99) < 38) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    cmd_ch.valid        = 1'b1;
    cmd_ch.action       = act;
    cmd_ch.req_size     = bfa_pkg::REQ_W'(size);
    cmd_ch.payload_addr = bfa_pkg::ADDR_W'(addr);
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic free_live();
    int idx;
    idx        = $urandom_range(live_addrs.size() - 1);
    last_freed = live_addrs[idx];
    live_addrs.delete(idx);
    send_cmd(bfa_pkg::ACT_FREE, $urandom_range(0, 1024), last_freed);
  endtask

  // Stray frees: a random offset, null, or the last freed offset
  task automatic send_noise();
    int pick;
    pick = $urandom_range(2);
    case (pick)
      0:       send_cmd(bfa_pkg::ACT_FREE, $urandom_range(0, 1024), $urandom_range(0, 1023));
      1:       send_cmd(bfa_pkg::ACT_FREE, $urandom_range(0, 1024), 0);
      default: send_cmd(bfa_pkg::ACT_FREE, $urandom_range(0, 1024), last_freed);
    endcase
  endtask

  task automatic pause_until_drained();
    cmd_ch.valid = 1'b0;
    wait (results_due == 0);
    @(negedge clk);
  endtask

  initial begin
    int pick;
    int size;
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.action       = bfa_pkg::ACT_ALLOC;
    cmd_ch.req_size     = '0;
    cmd_ch.payload_addr = '0;
    last_freed          = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed: oversize, null and bad frees on the fresh heap
    send_cmd(bfa_pkg::ACT_ALLOC, 1024, 0);
    send_cmd(bfa_pkg::ACT_FREE, 2047, 0);
    send_cmd(bfa_pkg::ACT_FREE, 0, 16);
    send_cmd(bfa_pkg::ACT_FREE, 1024, 1023);
    // Zero-byte block, then a row of alternating sizes
    send_cmd(bfa_pkg::ACT_ALLOC, 0, 1023);
    send_cmd(bfa_pkg::ACT_ALLOC, 20, 0);
    send_cmd(bfa_pkg::ACT_ALLOC, 8, 0);
    send_cmd(bfa_pkg::ACT_ALLOC, 20, 0);
    send_cmd(bfa_pkg::ACT_ALLOC, 8, 0);
    // Two equal free holes: earliest wins, then a whole grant without split
    send_cmd(bfa_pkg::ACT_FREE, 0, 32);
    send_cmd(bfa_pkg::ACT_FREE, 0, 92);
    send_cmd(bfa_pkg::ACT_ALLOC, 20, 0);
    send_cmd(bfa_pkg::ACT_ALLOC, 5, 0);
    // Double free, then merges on both sides back to one block
    send_cmd(bfa_pkg::ACT_FREE, 0, 92);
    send_cmd(bfa_pkg::ACT_FREE, 0, 92);
    send_cmd(bfa_pkg::ACT_FREE, 0, 68);
    send_cmd(bfa_pkg::ACT_FREE, 0, 16);
    send_cmd(bfa_pkg::ACT_FREE, 0, 32);
    send_cmd(bfa_pkg::ACT_FREE, 0, 128);
    // Whole heap, nothing left, near-whole, and the top offset
    send_cmd(bfa_pkg::ACT_ALLOC, 1008, 0);
    send_cmd(bfa_pkg::ACT_ALLOC, 0, 0);
    send_cmd(bfa_pkg::ACT_FREE, 0, 16);
    send_cmd(bfa_pkg::ACT_ALLOC, 992, 0);
    send_cmd(bfa_pkg::ACT_FREE, 0, 16);
    send_cmd(bfa_pkg::ACT_ALLOC, 991, 0);
    send_cmd(bfa_pkg::ACT_ALLOC, 1, 0);
    send_cmd(bfa_pkg::ACT_FREE, 0, 1023);
    send_cmd(bfa_pkg::ACT_FREE, 0, 16);
    pause_until_drained();
    live_addrs.delete();

    // Random episodes
    while (sent_count < WORK_ITEMS) begin
      if ($urandom_range(9) < 2) begin
        // Fill the table with small blocks, then release them all
        repeat ($urandom_range(20, 70)) begin
          send_cmd(bfa_pkg::ACT_ALLOC, $urandom_range(0, 24), $urandom_range(0, 1023));
        end
        pause_until_drained();
        while (live_addrs.size() > 0) begin
          if ($urandom_range(9) == 0) send_noise();
          free_live();
        end
      end else begin
        repeat ($urandom_range(10, 40)) begin
          pick = $urandom_range(99);
          if (pick < 45 || (pick < 85 && live_addrs.size() == 0)) begin
            pick = $urandom_range(99);
            if (pick < 70)      size = $urandom_range(0, 64);
            else if (pick < 90) size = $urandom_range(0, 300);
            else if (pick < 98) size = $urandom_range(300, 1008);
            else                size = $urandom_range(1009, 1024);
            send_cmd(bfa_pkg::ACT_ALLOC, size, $urandom_range(0, 1023));
          end else if (pick < 85) begin
            free_live();
          end else begin
            send_noise();
          end
        end
      end
    end

    // Drain and verdict
    cmd_ch.valid = 1'b0;
    wait (results_due == 0);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("best_fit_block_allocator verification clean");
    end else begin
      $display("best_fit_block_allocator verification failed");
    end
    $finish;
  end

endmodule
